FILE: rtl/hpg_pkg.sv
// ----------------------------------------------------------------------------
// Heap permutation generator package
// Shared widths, reset values and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package hpg_pkg;

	localparam int VAL_W      = 4;   // bits of one stored element value
	localparam int CNT_BITS   = 4;   // bits of one swap counter
	localparam int PERM_SLOTS = 16;  // positions in the packed output word
	localparam int WORD_W     = VAL_W * PERM_SLOTS;
	localparam int NCFG_W     = 5;   // element count register width

	localparam logic [NCFG_W-1:0] N_RESET = 5'd4;

	typedef struct packed {
		logic accept;    // latch a new input transaction, rewind the scan
		logic clear;     // restart: identity arrangement, counters to zero
		logic step;      // clear the counter at the scan position, move up
		logic found;     // bump the counter, read both swap operands
		logic set_done;  // the scan ran past the last position
		logic write_a;   // write the first half of the swap
		logic write_b;   // write the second half of the swap
		logic load_out;  // load the output register
	} cmd_t;

	typedef struct packed {
		logic restart;   // the pending transaction is a restart
		logic done;      // sequence already exhausted
		logic past_end;  // scan position has reached the element count
		logic found;     // counter at the scan position is below its index
		logic out_free;  // output register can take a new result
	} sts_t;

endpackage

FILE: rtl/hpg_if.sv
// ----------------------------------------------------------------------------
// Heap permutation generator channels
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------
interface hpg_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface hpg_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] perm_word;
	logic        exhausted;

	modport source (output valid, output perm_word, output exhausted, input ready);
	modport sink   (input valid, input perm_word, input exhausted, output ready);
endinterface

FILE: rtl/hpg_ctrl.sv
// ----------------------------------------------------------------------------
// Heap permutation generator controller
// Sequences one transaction: scan, swap written in the WRA and WRB states, then result hand-off.
// ----------------------------------------------------------------------------
module hpg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hpg_pkg::sts_t sts,
	output hpg_pkg::cmd_t cmd
);
	import hpg_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_WRA  = 5'b00100,
		ST_WRB  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				priority if (sts.restart) begin
					cmd.clear = 1'b1;
					state_d   = ST_FIN;
				end else if (sts.done) begin
					state_d = ST_FIN;
				end else if (sts.past_end) begin
					cmd.set_done = 1'b1;
					state_d      = ST_FIN;
				end else if (sts.found) begin
					cmd.found = 1'b1;
					state_d   = ST_WRA;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_WRA: begin
				cmd.write_a = 1'b1;
				state_d     = ST_WRB;
			end
			ST_WRB: begin
				cmd.write_b = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/hpg_dp.sv
// ----------------------------------------------------------------------------
// Heap permutation generator datapath
// Swap counters, arrangement store with its packed copy, scan position and
// the output register.
// ----------------------------------------------------------------------------
module hpg_dp #(
	parameter int MAX_ELEMENTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hpg_pkg::cmd_t                     cmd,
	output hpg_pkg::sts_t                     sts,
	input  logic                              in_restart,
	input  logic                              cfg_we,
	input  logic [hpg_pkg::NCFG_W-1:0]        cfg_wdata,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [hpg_pkg::WORD_W-1:0]        out_perm_word,
	output logic                              out_exhausted
);
	import hpg_pkg::*;

	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int CMP_W = CNT_BITS + 1;

	logic [NCFG_W-1:0]                    n_q;
	logic                                 restart_q;
	logic                                 done_q;
	logic [CNT_W-1:0]                     idx_q;
	logic [MAX_ELEMENTS-1:0][CNT_BITS-1:0] cnt_q;
	logic [MAX_ELEMENTS-1:0]              vld_q;
	logic [MAX_ELEMENTS-1:0][VAL_W-1:0]   arr_q;
	logic [VAL_W-1:0]                     mem [MAX_ELEMENTS];
	logic [VAL_W-1:0]                     rd_i_q;
	logic [VAL_W-1:0]                     rd_o_q;
	logic                                 rv_i_q;
	logic                                 rv_o_q;
	logic [IDX_W-1:0]                     oth_q;
	logic                                 out_valid_q;
	logic [WORD_W-1:0]                    out_word_q;
	logic                                 out_exh_q;

	logic [CNT_W-1:0]    n_eff;
	logic [IDX_W-1:0]    idx;
	logic [CNT_BITS-1:0] cur_cnt;
	logic                found;
	logic                past_end;
	logic [IDX_W-1:0]    oth_sel;
	logic [VAL_W-1:0]    val_i;
	logic [VAL_W-1:0]    val_o;
	logic [IDX_W-1:0]    wr_addr;
	logic [VAL_W-1:0]    wr_data;
	logic [WORD_W-1:0]   packed_word;

	// A count of zero behaves as one, a count above the build size as the build size.
	always_comb begin
		priority if (n_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (n_q > NCFG_W'(MAX_ELEMENTS)) begin
			n_eff = CNT_W'(MAX_ELEMENTS);
		end else begin
			n_eff = CNT_W'(n_q);
		end
	end

	assign idx      = idx_q[IDX_W-1:0];
	assign cur_cnt  = cnt_q[idx];
	assign past_end = (idx_q >= n_eff);
	assign found    = (CMP_W'(cur_cnt) < CMP_W'(idx_q));

	// Even positions swap with position zero, odd ones with the counter's position.
	always_comb begin
		if (!idx_q[0] || (CMP_W'(cur_cnt) >= CMP_W'(MAX_ELEMENTS))) begin
			oth_sel = '0;
		end else begin
			oth_sel = cur_cnt[IDX_W-1:0];
		end
	end

	// An entry not written since the last restart holds its own position.
	assign val_i   = rv_i_q ? rd_i_q : VAL_W'(idx);
	assign val_o   = rv_o_q ? rd_o_q : VAL_W'(oth_q);
	assign wr_addr = cmd.write_a ? oth_q : idx;
	assign wr_data = cmd.write_a ? val_i : val_o;

	assign sts.restart  = restart_q;
	assign sts.done     = done_q;
	assign sts.past_end = past_end;
	assign sts.found    = found;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= N_RESET;
			restart_q <= 1'b0;
			done_q    <= 1'b0;
			idx_q     <= '0;
			cnt_q     <= '0;
			vld_q     <= '0;
			for (int p = 0; p < MAX_ELEMENTS; p++) begin
				arr_q[p] <= VAL_W'(p);
			end
		end else begin
			if (cfg_we) begin
				n_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				restart_q <= in_restart;
				idx_q     <= '0;
			end
			if (cmd.clear) begin
				done_q <= 1'b0;
				cnt_q  <= '0;
				vld_q  <= '0;
				for (int p = 0; p < MAX_ELEMENTS; p++) begin
					arr_q[p] <= VAL_W'(p);
				end
			end
			if (cmd.set_done) begin
				done_q <= 1'b1;
			end
			if (cmd.step) begin
				cnt_q[idx] <= '0;
				idx_q      <= idx_q + CNT_W'(1);
			end
			if (cmd.found) begin
				cnt_q[idx] <= cur_cnt + CNT_BITS'(1);
			end
			if (cmd.write_a || cmd.write_b) begin
				vld_q[wr_addr] <= 1'b1;
				arr_q[wr_addr] <= wr_data;
			end
		end
	end

	// Arrangement store: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (cmd.write_a || cmd.write_b) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.found) begin
			rd_i_q <= mem[idx];
			rd_o_q <= mem[oth_sel];
			rv_i_q <= vld_q[idx];
			rv_o_q <= vld_q[oth_sel];
			oth_q  <= oth_sel;
		end
	end

	for (genvar p = 0; p < PERM_SLOTS; p++) begin : g_pack
		if (p < MAX_ELEMENTS) begin : g_used
			assign packed_word[p*VAL_W +: VAL_W] = (n_eff > CNT_W'(p)) ? arr_q[p] : '0;
		end else begin : g_unused
			assign packed_word[p*VAL_W +: VAL_W] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_word_q <= packed_word;
			out_exh_q  <= done_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_perm_word = out_word_q;
	assign out_exhausted = out_exh_q;

endmodule

FILE: rtl/heap_permutation_generator.sv
// ----------------------------------------------------------------------------
// Heap permutation generator
// Iterative Heap's algorithm over the values 0 to n-1, one arrangement per
// request transaction.
// ----------------------------------------------------------------------------
// Usage:
//   request: valid/ready channel; restart=1 loads the identity arrangement,
//   restart=0 asks for the next permutation. result: valid/ready channel with
//   the arrangement packed 4 bits per position (position 0 in bits 3..0,
//   positions at or above n zero) and an exhausted flag. Every request
//   transaction yields exactly one result transaction. The element count n
//   is written through cfg_we/cfg_wdata between transactions.
//   A restart clears the store and goes straight to hand-off; an advance
//   scans from position 0, clearing each counter it passes, then swaps; the
//   advance that runs out sets the exhausted flag; one after exhaustion
//   goes straight to hand-off. The scan visits one position per cycle and
//   the swap writes its two halves in turn on the single write port of the
//   arrangement store. A new request is taken in the cycle after the result
//   is loaded, so one item is finished before the next is taken.
//   Reset gives the identity arrangement, zero counters and n = 4. A stalled
//   result holds in the output register while the next request is taken;
//   the block waits only to load a further result into it.
// ----------------------------------------------------------------------------
module heap_permutation_generator #(
	parameter int MAX_ELEMENTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	hpg_in_if.sink                     request,
	hpg_out_if.source                  result,
	input  logic                       cfg_we,
	input  logic [hpg_pkg::NCFG_W-1:0] cfg_wdata
);
	import hpg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (request.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hpg_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_restart    (request.restart),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.out_perm_word (result.perm_word),
		.out_exhausted (result.exhausted)
	);

endmodule

FILE: rtl/hpg_checker.sv
// ----------------------------------------------------------------------------
// Heap permutation generator port checker
// Checks the handshake behavior seen at the ports of the top level.
// ----------------------------------------------------------------------------
module hpg_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_perm_word,
	input logic        out_exhausted
);

	// A pending result stays offered until it is taken.
	a_out_hold : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped before the transaction completed");

	// A stalled result keeps its payload.
	a_out_stable : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_perm_word) && $stable(out_exhausted))
		else $error("result payload changed while stalled");

	// Only one request is in progress at a time.
	a_one_inflight : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another one is still in progress");

	// A result never appears the cycle right after a request is taken.
	a_no_bypass : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared without going through the scan");

endmodule

bind heap_permutation_generator hpg_port_checker u_hpg_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (request.valid),
	.in_ready      (request.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_perm_word (result.perm_word),
	.out_exhausted (result.exhausted)
);
